FILE: rtl/atpr_pkg.sv
package atpr_pkg;

    // Output angle scale: degrees times 2**ANGLE_FRAC_BITS.
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int CORDIC_FRAC  = 20;
    localparam int CORDIC_STEPS = 24;
    localparam int NORM_STEPS   = 5;
    localparam int NORM_W       = 62;
    localparam int SQRT_STEPS   = NORM_W / 2;
    localparam int ROOT_W       = NORM_W + 1;
    localparam int CX_W         = 34;
    localparam int Z_W          = 28;
    localparam int AX_W         = 27;
    localparam int MAG_W        = 26;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SUM_W        = SQ_W + 1;

    localparam int ANGLE_FULL  = 90 << ANGLE_FRAC_BITS;
    localparam int ANGLE_LIMIT = (ANGLE_FULL > 32767) ? 32767 : ANGLE_FULL;

    // Register select, taken from paddr[2].
    localparam logic REG_SENS = 1'b0;
    localparam logic REG_OFFS = 1'b1;

    typedef enum logic [1:0] {
        SP_NORM  = 2'd0,
        SP_FULL  = 2'd1,
        SP_ZERO  = 2'd2,
        SP_DEGEN = 2'd3
    } t_special;

    // atan(2**-i) in degrees with CORDIC_FRAC fraction bits.
    function automatic logic signed [Z_W-1:0] atan_deg(input int i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:  v = 28'sd47185920;
            1:  v = 28'sd27855475;
            2:  v = 28'sd14718068;
            3:  v = 28'sd7471121;
            4:  v = 28'sd3750058;
            5:  v = 28'sd1876857;
            6:  v = 28'sd938658;
            7:  v = 28'sd469357;
            8:  v = 28'sd234682;
            9:  v = 28'sd117342;
            10: v = 28'sd58671;
            11: v = 28'sd29335;
            12: v = 28'sd14668;
            13: v = 28'sd7334;
            14: v = 28'sd3667;
            15: v = 28'sd1833;
            16: v = 28'sd917;
            17: v = 28'sd458;
            18: v = 28'sd229;
            19: v = 28'sd115;
            20: v = 28'sd57;
            21: v = 28'sd29;
            22: v = 28'sd14;
            23: v = 28'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/atpr_angle.sv
module atpr_angle import atpr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [SUM_W-1:0]         i_num,
    input  logic [SUM_W-1:0]         i_den,
    input  logic                     i_neg,
    output logic                     o_valid,
    output logic signed [15:0]       o_angle,
    output logic                     o_degen
);

    localparam int LAST = NORM_STEPS + SQRT_STEPS + CORDIC_STEPS;
    localparam int SH   = CORDIC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] ZMAX = Z_W'(90 << CORDIC_FRAC);
    localparam logic [Z_W-1:0] HALF = Z_W'(1) << (SH - 1);
    localparam logic [Z_W-1:0] FULL = Z_W'(ANGLE_FULL);

    logic     r_vld [0:LAST];
    t_special r_sp  [0:LAST];
    logic     r_neg [0:LAST];
    t_special w_sp;

    logic [NORM_W-1:0] r_nm [0:NORM_STEPS];
    logic [NORM_W-1:0] r_nn [0:NORM_STEPS];
    logic [NORM_W-1:0] r_nd [0:NORM_STEPS];

    logic [NORM_W-1:0] r_qvn [1:SQRT_STEPS];
    logic [NORM_W-1:0] r_qvd [1:SQRT_STEPS];
    logic [ROOT_W-1:0] r_qrn [1:SQRT_STEPS];
    logic [ROOT_W-1:0] r_qrd [1:SQRT_STEPS];

    logic signed [CX_W-1:0] r_cx [1:CORDIC_STEPS];
    logic signed [CX_W-1:0] r_cy [1:CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_cz [1:CORDIC_STEPS];

    always_comb begin
        priority if (i_den == '0) begin
            w_sp = (i_num == '0) ? SP_DEGEN : SP_FULL;
        end else if (i_num == '0) begin
            w_sp = SP_ZERO;
        end else begin
            w_sp = SP_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t <= LAST; t++) r_vld[t] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int t = 1; t <= LAST; t++) r_vld[t] <= r_vld[t-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp[0]  <= w_sp;
            r_neg[0] <= i_neg;
            for (int t = 1; t <= LAST; t++) begin
                r_sp[t]  <= r_sp[t-1];
                r_neg[t] <= r_neg[t-1];
            end
            r_nn[0] <= NORM_W'(i_num);
            r_nd[0] <= NORM_W'(i_den);
            r_nm[0] <= (i_num > i_den) ? NORM_W'(i_num) : NORM_W'(i_den);
        end
    end

    // Normalize by powers of four until the larger operand reaches 2**60.
    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        localparam int P = 1 << (NORM_STEPS - 1 - g);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_nm[g] < (NORM_W'(1) << (NORM_W - 2 * P))) begin
                    r_nm[g+1] <= r_nm[g] << (2 * P);
                    r_nn[g+1] <= r_nn[g] << (2 * P);
                    r_nd[g+1] <= r_nd[g] << (2 * P);
                end else begin
                    r_nm[g+1] <= r_nm[g];
                    r_nn[g+1] <= r_nn[g];
                    r_nd[g+1] <= r_nd[g];
                end
            end
        end
    end

    // Digit-by-digit square roots, one result bit per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (NORM_W - 2 - 2 * j);
        logic [NORM_W-1:0] vn_in, vd_in;
        logic [ROOT_W-1:0] rn_in, rd_in, tn, td;
        if (j == 0) begin : g_first
            assign vn_in = r_nn[NORM_STEPS];
            assign vd_in = r_nd[NORM_STEPS];
            assign rn_in = '0;
            assign rd_in = '0;
        end else begin : g_next
            assign vn_in = r_qvn[j];
            assign vd_in = r_qvd[j];
            assign rn_in = r_qrn[j];
            assign rd_in = r_qrd[j];
        end
        assign tn = rn_in + BIT;
        assign td = rd_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, vn_in} >= tn) begin
                    r_qvn[j+1] <= vn_in - tn[NORM_W-1:0];
                    r_qrn[j+1] <= (rn_in >> 1) + BIT;
                end else begin
                    r_qvn[j+1] <= vn_in;
                    r_qrn[j+1] <= rn_in >> 1;
                end
                if ({1'b0, vd_in} >= td) begin
                    r_qvd[j+1] <= vd_in - td[NORM_W-1:0];
                    r_qrd[j+1] <= (rd_in >> 1) + BIT;
                end else begin
                    r_qvd[j+1] <= vd_in;
                    r_qrd[j+1] <= rd_in >> 1;
                end
            end
        end
    end

    // Vectoring CORDIC, one rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CX_W-1:0] cx_in, cy_in, sx, sy;
        logic signed [Z_W-1:0]  cz_in;
        if (i == 0) begin : g_first
            assign cx_in = $signed({3'b000, r_qrd[SQRT_STEPS][30:0]});
            assign cy_in = $signed({3'b000, r_qrn[SQRT_STEPS][30:0]});
            assign cz_in = '0;
        end else begin : g_next
            assign cx_in = r_cx[i];
            assign cy_in = r_cy[i];
            assign cz_in = r_cz[i];
        end
        assign sx = cx_in >>> i;
        assign sy = cy_in >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (cy_in > 0) begin
                    r_cx[i+1] <= cx_in + sy;
                    r_cy[i+1] <= cy_in - sx;
                    r_cz[i+1] <= cz_in + atan_deg(i);
                end else begin
                    r_cx[i+1] <= cx_in - sy;
                    r_cy[i+1] <= cy_in + sx;
                    r_cz[i+1] <= cz_in - atan_deg(i);
                end
            end
        end
    end

    logic signed [Z_W-1:0] w_zc;
    logic [Z_W-1:0]        w_mag;
    logic signed [Z_W:0]   w_val;
    logic signed [15:0]    w_sat;

    always_comb begin
        if (r_cz[CORDIC_STEPS] < 0) begin
            w_zc = '0;
        end else if (r_cz[CORDIC_STEPS] > ZMAX) begin
            w_zc = ZMAX;
        end else begin
            w_zc = r_cz[CORDIC_STEPS];
        end
        unique case (r_sp[LAST])
            SP_NORM: w_mag = (w_zc + HALF) >> SH;
            SP_FULL: w_mag = FULL;
            default: w_mag = '0;
        endcase
        w_val = r_neg[LAST] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        if (w_val > 32767) begin
            w_sat = 16'sh7fff;
        end else if (w_val < -32768) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_val[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= w_sat;
            o_degen <= (r_sp[LAST] == SP_DEGEN);
        end
    end

endmodule

FILE: rtl/accel_tilt_pitch_roll_core.sv
// Throughput: one request per cycle; three input stages, 61 stages per angle lane and the
// output register all advance together, and move whenever the output register is free.
// A held output stalls the whole pipeline, and nothing is lost or repeated.
// Reset (synchronous, active low) clears every valid bit and loads the registers with
// sensitivity 61 and offset 20000; datapath registers are not reset.
module accel_tilt_pitch_roll_core import atpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // Sample stream in.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    // Angle stream out.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // tilt_deg[15:0], pitch_deg[31:16], roll_deg[47:32]
    output logic        o_m_tuser    // degenerate[0]
);

    // Configuration registers. The register is chosen by paddr[2] alone.
    logic [9:0]         r_sens;
    logic signed [17:0] r_offs;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= 10'd61;
            r_offs <= 18'sd20000;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[2])
                REG_SENS: r_sens <= i_pwdata[9:0];
                REG_OFFS: r_offs <= i_pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_SENS: o_prdata = {22'd0, r_sens};
            REG_OFFS: o_prdata = {14'd0, r_offs};
            default:  o_prdata = '0;
        endcase
    end

    // The whole pipeline moves while the output register is empty or being drained.
    logic w_en;
    logic w_lane_vld [3];
    logic signed [15:0] w_angle [3];
    logic w_degen [3];

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Stage 1: scale each axis to micro-g (one 16x11 multiply and the offset add).
    logic signed [AX_W-1:0] r_ax [3];
    logic signed [AX_W-1:0] w_prod [3];
    logic r_v1, r_v2, r_v3;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_prod[a] = $signed(i_s_tdata[16*a +: 16]) * $signed({1'b0, r_sens});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) r_ax[a] <= w_prod[a] + AX_W'(r_offs);
        end
    end

    // Stage 2: magnitudes and their squares; the axis signs travel alongside.
    logic [MAG_W-1:0] w_mag [3];
    logic [SQ_W-1:0]  r_sq [3];
    logic             r_sg [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = r_ax[a][AX_W-1] ? MAG_W'(-r_ax[a]) : MAG_W'(r_ax[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= w_mag[a] * w_mag[a];
                r_sg[a] <= r_ax[a][AX_W-1];
            end
        end
    end

    // Stage 3: numerator and denominator squares of each angle.
    // Lane 0 is tilt, lane 1 pitch, lane 2 roll.
    logic [SUM_W-1:0] r_num [3];
    logic [SUM_W-1:0] r_den [3];
    logic             r_neg [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num[0] <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]);
            r_den[0] <= SUM_W'(r_sq[2]);
            r_neg[0] <= r_sg[2];
            r_num[1] <= SUM_W'(r_sq[0]);
            r_den[1] <= SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_neg[1] <= r_sg[0];
            r_num[2] <= SUM_W'(r_sq[1]);
            r_den[2] <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[2]);
            r_neg[2] <= r_sg[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Each lane normalizes, takes both square roots, runs the CORDIC and rounds.
    for (genvar l = 0; l < 3; l++) begin : g_lane
        atpr_angle u_angle (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_v3),
            .i_num   (r_num[l]),
            .i_den   (r_den[l]),
            .i_neg   (r_neg[l]),
            .o_valid (w_lane_vld[l]),
            .o_angle (w_angle[l]),
            .o_degen (w_degen[l])
        );
    end

    // The lanes' output registers form the output register of the block.
    assign o_m_tvalid = w_lane_vld[0];
    assign o_m_tdata  = {w_angle[2], w_angle[1], w_angle[0]};
    assign o_m_tuser  = w_degen[0] || w_degen[1] || w_degen[2];

`ifndef SYNTH
    // All three lanes see the same valid pattern and must stay in step.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lane_vld[0] == w_lane_vld[1]) && (w_lane_vld[0] == w_lane_vld[2]))
        else $error("angle lanes out of step");

    // Zero over zero only happens with all axes zero, so every angle is zero.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("degenerate result with a nonzero angle");

    // Every angle stays within plus or minus ninety degrees.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            $signed(o_m_tdata[15:0])  <= ANGLE_LIMIT && $signed(o_m_tdata[15:0])  >= -ANGLE_LIMIT &&
            $signed(o_m_tdata[31:16]) <= ANGLE_LIMIT && $signed(o_m_tdata[31:16]) >= -ANGLE_LIMIT &&
            $signed(o_m_tdata[47:32]) <= ANGLE_LIMIT && $signed(o_m_tdata[47:32]) >= -ANGLE_LIMIT)
        else $error("angle out of range");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
    import atpr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    // One raw accelerometer sample, as it travels on the input stream.
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } sample_t;

    // The three angles and the zero-over-zero flag of one result.
    typedef struct {
        logic signed [15:0] tilt;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               degen;
    } angles_t;

    // atan(2**-i) in degrees with CORDIC_FRAC fraction bits.
    localparam longint ATAN_STEP_DEG [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // tilt_deg[15:0], pitch_deg[31:16], roll_deg[47:32]
    logic        o_m_tuser;   // degenerate[0]

    accel_tilt_pitch_roll_core i_dut (.*);

    // Shadow copy of the two configuration registers.
    logic [9:0]         shadow_sens;
    logic signed [17:0] shadow_offs;

    sample_t samples_to_send[$];
    angles_t pending_angles[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  recv_holdoff;
    bit  sender_hold;
    int  mismatches;
    int  results_seen;
    int  degen_seen;
    int  samples_sent;
    int  cycle_count;

    // Integer square root, bit by bit, floor of the exact root.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // atan(num/den) in output units from the squared operands. The sign is given
    // separately; the result saturates to 16 bits.
    function automatic logic signed [15:0] atan_ratio(longint unsigned num_sq,
                                                      longint unsigned den_sq,
                                                      bit neg, inout bit degen);
        longint          res;
        longint unsigned m;
        int              k;
        longint          cx, cy, nx, ny, z;
        int              sh;
        sh = CORDIC_FRAC - ANGLE_FRAC_BITS;
        if (den_sq == 0) begin
            if (num_sq == 0) begin
                degen = 1'b1;
                return '0;
            end
            res = longint'(90) << ANGLE_FRAC_BITS;
        end else if (num_sq == 0) begin
            return '0;
        end else begin
            m = (num_sq > den_sq) ? num_sq : den_sq;
            k = 0;
            while (m < (64'd1 << 60)) begin
                m <<= 2;
                k++;
            end
            cy = longint'(int_sqrt(num_sq << (2 * k)));
            cx = longint'(int_sqrt(den_sq << (2 * k)));
            z = 0;
            // Vectoring CORDIC: drive y to zero and accumulate the rotation.
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (cy > 0) begin
                    nx = cx + (cy >>> i);
                    ny = cy - (cx >>> i);
                    z += ATAN_STEP_DEG[i];
                end else begin
                    nx = cx - (cy >>> i);
                    ny = cy + (cx >>> i);
                    z -= ATAN_STEP_DEG[i];
                end
                cx = nx;
                cy = ny;
            end
            if (z < 0)
                z = 0;
            if (z > (longint'(90) << CORDIC_FRAC))
                z = longint'(90) << CORDIC_FRAC;
            res = (z + (longint'(1) << (sh - 1))) >>> sh;
        end
        if (neg)
            res = -res;
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[15:0];
    endfunction

    // Scales the three axes to micro-g and forms the three angles.
    function automatic angles_t predict_angles(sample_t s);
        angles_t         a;
        longint          ax, ay, az;
        longint unsigned sx, sy, sz;
        bit              degen;
        ax = longint'(s.x) * longint'(shadow_sens) + longint'(shadow_offs);
        ay = longint'(s.y) * longint'(shadow_sens) + longint'(shadow_offs);
        az = longint'(s.z) * longint'(shadow_sens) + longint'(shadow_offs);
        sx = (ax < 0 ? -ax : ax) * (ax < 0 ? -ax : ax);
        sy = (ay < 0 ? -ay : ay) * (ay < 0 ? -ay : ay);
        sz = (az < 0 ? -az : az) * (az < 0 ? -az : az);
        degen = 1'b0;
        a.tilt  = atan_ratio(sx + sy, sz, az < 0, degen);
        a.pitch = atan_ratio(sx, sy + sz, ax < 0, degen);
        a.roll  = atan_ratio(sy, sx + sz, ay < 0, degen);
        a.degen = degen;
        return a;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample driver. A request is retired when tvalid and tready meet; the next one
    // is offered from the queue unless the sender idles this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_angles.push_back(predict_angles(sample_t'(i_s_tdata)));
                samples_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (samples_to_send.size() != 0 && !sender_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= samples_to_send.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure.
    always @(posedge i_clk) begin
        angles_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (o_m_tuser)
                    degen_seen++;
                if (pending_angles.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result %h/%b", o_m_tdata, o_m_tuser);
                end else begin
                    want = pending_angles.pop_front();
                    if (o_m_tdata[15:0] !== want.tilt || o_m_tdata[31:16] !== want.pitch ||
                        o_m_tdata[47:32] !== want.roll || o_m_tuser !== want.degen) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d: tilt/pitch/roll/degen expected ",
                                      "%0d %0d %0d %b, got %0d %0d %0d %b"},
                                     results_seen, want.tilt, want.pitch, want.roll,
                                     want.degen, $signed(o_m_tdata[15:0]),
                                     $signed(o_m_tdata[31:16]), $signed(o_m_tdata[47:32]),
                                     o_m_tuser);
                    end
                end
            end
            if (recv_holdoff > 0) begin
                recv_holdoff <= recv_holdoff - 1;
                i_m_tready   <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_angles.size());
            $display("** accel_tilt_pitch_roll_core: FAILED **");
            $finish;
        end
    end

    // APB write: a setup cycle, then an access cycle; the shadow follows the write.
    task automatic write_reg(input logic sel, input logic [31:0] value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {sel, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        if (sel == REG_SENS)
            shadow_sens = value[9:0];
        else
            shadow_offs = value[17:0];
    endtask

    task automatic set_config(input logic [9:0] sens, input logic signed [17:0] offs);
        write_reg(REG_SENS, {22'd0, sens});
        write_reg(REG_OFFS, {{14{offs[17]}}, offs});
    endtask

    // Blocks until every queued request is accepted and every result has come back,
    // then lets the pipeline run dry.
    task automatic wait_idle();
        while (samples_to_send.size() != 0 || i_s_tvalid || pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
        sample_t s;
        s.x = x;
        s.y = y;
        s.z = z;
        samples_to_send.push_back(s);
    endtask

    function automatic logic [15:0] random_axis();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(8) - 4);         // near zero
            1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
            2:       return 16'($urandom_range(400) - 200);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_random(input int count);
        for (int n = 0; n < count; n++)
            add_sample(random_axis(), random_axis(), random_axis());
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_psel       = 1'b0;
        i_penable    = 1'b0;
        i_pwrite     = 1'b0;
        i_paddr      = '0;
        i_pwdata     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_holdoff = 0;
        sender_hold  = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        degen_seen   = 0;
        samples_sent = 0;
        cycle_count  = 0;
        shadow_sens  = 10'd61;
        shadow_offs  = 18'sd20000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples with the reset configuration: axis extremes and zeros.
        add_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_sample(16'sh8000, 16'sh8000, 16'sh8000);
        add_sample(16'sh7fff, 16'sh8000, 0);
        add_sample(0, 0, 0);
        add_sample(-328, -328, -328);
        add_sample(16'sh8000, 0, 16'sh7fff);
        wait_idle();

        // Unit scale, no offset: nonzero over zero for each angle, zero over nonzero,
        // and the all-zero sample that is flagged as degenerate.
        set_config(10'd1, 18'sd0);
        add_sample(0, 0, 0);
        add_sample(5, 0, 0);
        add_sample(-5, 0, 0);
        add_sample(0, 7, 0);
        add_sample(0, -7, 0);
        add_sample(0, 0, 9);
        add_sample(0, 0, -9);
        add_sample(1, 1, 1);
        add_sample(-1, 1, -1);
        wait_idle();

        // Zero sensitivity: every axis is the offset, so zero offset is degenerate.
        set_config(10'd0, 18'sd0);
        add_sample(16'sh1234, 16'sh8000, 16'sh7fff);
        wait_idle();
        set_config(10'd1000, -18'sd100000);
        add_sample(100, 100, 100);
        add_sample(100, -100, 100);
        add_sample(16'sh7fff, 100, 16'sh8000);
        wait_idle();

        // Random phases, each with its own registers and idling pattern.
        set_config(10'd1023, -18'sd131072);
        set_idling(0, 0);
        add_random(250);
        wait_idle();

        set_config(10'd61, 18'sd20000);
        set_idling(57, 0);
        add_random(250);
        wait_idle();

        set_config(10'd0, 18'sd131071);
        set_idling(0, 57);
        add_random(100);
        wait_idle();

        set_config(10'd1, -18'sd1);
        set_idling(0, 57);
        add_random(150);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering, so the pipeline fills
        // and stalls its input; then a sender pause until all results are back.
        set_config(10'($urandom_range(1023)), 18'($urandom_range(262143)));
        set_idling(0, 0);
        @(posedge i_clk);
        recv_holdoff <= 300;
        add_random(200);
        while (samples_to_send.size() > 100)
            @(posedge i_clk);
        sender_hold = 1'b1;
        while (pending_angles.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        sender_hold = 1'b0;
        wait_idle();

        set_config(10'($urandom_range(1023)), 18'($urandom_range(262143)));
        set_idling(24, 24);
        add_random(300);
        wait_idle();

        $display("%0d samples sent, %0d results checked (%0d degenerate), 9 register settings",
                 samples_sent, results_seen, degen_seen);
        $display("covered zero/nonzero special cases, saturated axes and stall patterns");
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("** accel_tilt_pitch_roll_core: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** accel_tilt_pitch_roll_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/atpr_pkg.sv
rtl/atpr_angle.sv
rtl/accel_tilt_pitch_roll_core.sv
dv/testbench.sv
